/* sv/adg_pkg.sv */
// Shared constants, activation kind codes and ROM builders for the activation derivative unit.
// No dependencies; imported by the top level and by its checker.
package adg_pkg;

   localparam int FRAC_BITS     = 12;
   localparam int TABLE_ENTRIES = 256;

   localparam int ROM_W    = 17;
   localparam int ROM_LEN  = TABLE_ENTRIES + 2;
   localparam int IDX_W    = $clog2(ROM_LEN);
   localparam int WGT_W    = 15;
   localparam int MAG_W    = 17;
   localparam int PROD_W   = MAG_W + $clog2(TABLE_ENTRIES + 1);
   localparam int FACTOR_W = 32;

   localparam int          TENTH_SHIFT = 19;
   localparam logic [15:0] RECIP_TENTH = 16'd52429;
   localparam int          TENTH_W     = 12;

   localparam logic [63:0] ONE_Q31 = 64'd1 << 31;

   typedef enum logic [2:0] {
      KIND_LINEAR  = 3'd0,
      KIND_RELU    = 3'd1,
      KIND_LEAKY   = 3'd2,
      KIND_SIGMOID = 3'd3,
      KIND_ELU     = 3'd4
   } kind_type;

   typedef logic [ROM_LEN-1:0][ROM_W-1:0] rom_type;

   function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
      logic [63:0]        term;
      logic signed [63:0] sum;
      term = ONE_Q31;
      sum  = $signed(ONE_Q31);
      for (int i = 1; i <= 24; i++) begin
         term = ((term * f) >> 31) / 64'(i);
         if (i % 2 == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      if (sum > $signed(ONE_Q31)) begin
         sum = $signed(ONE_Q31);
      end
      return 64'(sum);
   endfunction

   // restoring shift-and-subtract quotient
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [ROM_W-1:0] rom_point(input int k, input logic is_sig);
      logic [63:0] e1;
      logic [63:0] u;
      logic [63:0] n;
      logic [63:0] e;
      logic [63:0] d;
      logic [63:0] s;
      logic [63:0] sd;
      logic [63:0] v;
      e1 = exp_neg_frac(ONE_Q31);
      u  = (64'(k) << (46 - FRAC_BITS)) / TABLE_ENTRIES;
      n  = u >> 31;
      e  = exp_neg_frac(u & (ONE_Q31 - 64'd1));
      while (n > 0 && e != 0) begin
         e = (e * e1) >> 31;
         n = n - 64'd1;
      end
      d = ONE_Q31 + e;
      s = udiv64((64'd1 << 62) + (d >> 1), d);
      if (s > ONE_Q31) begin
         s = ONE_Q31;
      end
      sd = (s * (ONE_Q31 - s)) >> 31;
      v  = is_sig ? sd : e;
      v  = (v + (64'd1 << 14)) >> 15;
      return v[ROM_W-1:0];
   endfunction

   function automatic rom_type build_rom(input logic is_sig);
      rom_type rom;
      for (int k = 0; k <= TABLE_ENTRIES; k++) begin
         rom[k] = rom_point(k, is_sig);
      end
      rom[TABLE_ENTRIES + 1] = rom[TABLE_ENTRIES];
      return rom;
   endfunction

endpackage

/* sv/activation_derivative_gradient.sv */
// Top level of the activation derivative unit: five-stage pipeline with the exp and s(1-s) ROMs.
// Depends on adg_pkg for constants, kind codes and the ROM builders.

// One element per cycle while rsp_tready stays high, fully pipelined: a transfer on req_ is answered
// by a transfer on rsp_ once it has passed every stage. The stages are the magnitude and table index, the
// registered ROM read, the interpolation, the gradient product and the final round, select
// and saturate; the output register is the last stage. Each stage holds only while the one
// after it is full and stalled, so bubbles close up and the input keeps taking elements
// while a result waits. Write csr_data (activation kind) only while no element is in flight;
// kinds 5 to 7 behave as linear.
module activation_derivative_gradient (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] pre_activation, [31:16] upstream_gradient
   input  logic        req_tlast,   // last_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] gradient_out
   output logic        rsp_tlast,   // last_out
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_data     // [2:0] activation_kind
);
   import adg_pkg::*;

   localparam rom_type EXP_ROM = build_rom(1'b0);
   localparam rom_type SIG_ROM = build_rom(1'b1);

   logic [2:0] kind_ff;

   logic rdy1, rdy2, rdy3, rdy4, rdy5;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   logic signed [15:0] x_in;
   logic [MAG_W-1:0]   m_in;
   logic [PROD_W-1:0]  p_in;

   logic [IDX_W-1:0]   s1_idx_ff;
   logic [WGT_W-1:0]   s1_w_ff;
   logic signed [15:0] s1_y_ff;
   logic               s1_pos_ff;
   logic               s1_last_ff;

   logic [IDX_W-1:0]   idx_next;
   logic [ROM_W-1:0]   s2_lo_exp_ff, s2_hi_exp_ff, s2_lo_sig_ff, s2_hi_sig_ff;
   logic [WGT_W-1:0]   s2_w_ff;
   logic signed [15:0] s2_y_ff;
   logic               s2_pos_ff;
   logic               s2_last_ff;

   logic [ROM_W-1:0]    lo_sel, hi_sel;
   logic [15:0]         w_inv;
   logic [FACTOR_W-1:0] factor_in;
   logic [MAG_W-1:0]    mag_in;
   logic [33:0]         tenth_prod;
   logic [FACTOR_W-1:0] s3_factor_ff;
   logic [MAG_W-1:0]    s3_mag_ff;
   logic [TENTH_W-1:0]  s3_tenth_ff;
   logic signed [15:0]  s3_y_ff;
   logic                s3_pos_ff;
   logic                s3_last_ff;

   logic [MAG_W+FACTOR_W-1:0] s4_prod_ff;
   logic [TENTH_W-1:0]        s4_tenth_ff;
   logic signed [15:0]        s4_y_ff;
   logic                      s4_pos_ff;
   logic                      s4_last_ff;

   logic [MAG_W+FACTOR_W:0] rnd;
   logic [MAG_W-1:0]        q;
   logic signed [17:0]      y_ext, fac_s, tenth_s, r;
   logic [15:0]             out_in;
   logic [15:0]             out_ff;
   logic                    last_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_LINEAR;
      end else if (csr_valid && csr_ready) begin
         kind_ff <= csr_data;
      end
   end

   assign rdy5 = !v5_ff || rsp_tready;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_tready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   // stage 1: magnitude and table position
   always_comb begin
      x_in = $signed(req_tdata[15:0]);
      m_in = x_in[15] ? (17'd0 - {x_in[15], x_in}) : {1'b0, x_in};
      p_in = PROD_W'(m_in) * PROD_W'(TABLE_ENTRIES);
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_idx_ff  <= p_in[WGT_W+IDX_W-1:WGT_W];
         s1_w_ff    <= p_in[WGT_W-1:0];
         s1_y_ff    <= $signed(req_tdata[31:16]);
         s1_pos_ff  <= !x_in[15] && (x_in != 16'sd0);
         s1_last_ff <= req_tlast;
      end
   end

   // stage 2: registered ROM reads at idx and idx+1
   assign idx_next = s1_idx_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_lo_exp_ff <= EXP_ROM[s1_idx_ff];
         s2_hi_exp_ff <= EXP_ROM[idx_next];
         s2_lo_sig_ff <= SIG_ROM[s1_idx_ff];
         s2_hi_sig_ff <= SIG_ROM[idx_next];
         s2_w_ff      <= s1_w_ff;
         s2_y_ff      <= s1_y_ff;
         s2_pos_ff    <= s1_pos_ff;
         s2_last_ff   <= s1_last_ff;
      end
   end

   // stage 3: interpolation, gradient magnitude, tenth scaling
   always_comb begin
      if (kind_ff == KIND_SIGMOID) begin
         lo_sel = s2_lo_sig_ff;
         hi_sel = s2_hi_sig_ff;
      end else begin
         lo_sel = s2_lo_exp_ff;
         hi_sel = s2_hi_exp_ff;
      end
      w_inv      = 16'd32768 - {1'b0, s2_w_ff};
      factor_in  = FACTOR_W'(lo_sel) * FACTOR_W'(w_inv)
                 + FACTOR_W'(hi_sel) * FACTOR_W'(s2_w_ff);
      mag_in     = s2_y_ff[15] ? (17'd0 - {s2_y_ff[15], s2_y_ff}) : {1'b0, s2_y_ff};
      tenth_prod = (18'(mag_in) + 18'd5) * RECIP_TENTH;
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_factor_ff <= factor_in;
         s3_mag_ff    <= mag_in;
         s3_tenth_ff  <= tenth_prod[TENTH_SHIFT+TENTH_W-1:TENTH_SHIFT];
         s3_y_ff      <= s2_y_ff;
         s3_pos_ff    <= s2_pos_ff;
         s3_last_ff   <= s2_last_ff;
      end
   end

   // stage 4: gradient times factor
   always_ff @(posedge clock) begin
      if (rdy4) begin
         s4_prod_ff  <= s3_mag_ff * s3_factor_ff;
         s4_tenth_ff <= s3_tenth_ff;
         s4_y_ff     <= s3_y_ff;
         s4_pos_ff   <= s3_pos_ff;
         s4_last_ff  <= s3_last_ff;
      end
   end

   // stage 5: round, select, saturate
   always_comb begin
      rnd     = {1'b0, s4_prod_ff} + (50'd1 << 30);
      q       = rnd[MAG_W+30:31];
      y_ext   = 18'(s4_y_ff);
      fac_s   = s4_y_ff[15] ? (18'sd0 - $signed({1'b0, q})) : $signed({1'b0, q});
      tenth_s = s4_y_ff[15] ? (18'sd0 - $signed(18'(s4_tenth_ff)))
                            : $signed(18'(s4_tenth_ff));
      unique case (kind_ff)
         KIND_RELU:    r = s4_pos_ff ? y_ext : 18'sd0;
         KIND_LEAKY:   r = s4_pos_ff ? y_ext : tenth_s;
         KIND_SIGMOID: r = fac_s;
         KIND_ELU:     r = s4_pos_ff ? y_ext : fac_s;
         default:      r = y_ext;
      endcase
      priority if (r > 18'sd32767) begin
         out_in = 16'h7FFF;
      end else if (r < -18'sd32768) begin
         out_in = 16'h8000;
      end else begin
         out_in = r[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy5) begin
         out_ff  <= out_in;
         last_ff <= s4_last_ff;
      end
   end

   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = out_ff;
   assign rsp_tlast  = last_ff;

endmodule

/* sv/adg_checker.sv */
// Port-level checker for the activation derivative unit, bound to the top level.
// Depends on adg_pkg for the activation kind codes.
module adg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [2:0]  csr_data
);
   import adg_pkg::*;

   logic [2:0] kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= KIND_LINEAR;
      end else if (csr_valid && csr_ready) begin
         kind_ff <= csr_data;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with an empty output");

   a_sigmoid_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && kind_ff == KIND_SIGMOID
         |-> $signed(rsp_tdata) <= 16'sd8192 && $signed(rsp_tdata) >= -16'sd8192)
      else $error("sigmoid gradient above a quarter of the input");

endmodule

bind activation_derivative_gradient adg_checker u_adg_checker (.*);

/* tb/activation_derivative_gradient_test.sv */
// Self-checking testbench for activation_derivative_gradient: directed rows, then random phases.
// Predicts untyped gradients from its exp and s(1-s) tables; needs only adg_pkg and the top level.
module activation_derivative_gradient_test;
   import adg_pkg::*;

   typedef longint unsigned u64_type;

   typedef struct packed {
      logic [15:0] grad;
      logic        last;
   } grad_result_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] x;
      logic [15:0] y;
      logic        last;
      logic        known;
      logic [15:0] grad;
   } stim_row_type;

   localparam logic [2:0] KIND_SPARE5 = 3'd5;
   localparam logic [2:0] KIND_SPARE6 = 3'd6;
   localparam logic [2:0] KIND_SPARE7 = 3'd7;

   localparam logic [15:0] MOST_NEG = 16'h8000;
   localparam logic [15:0] MOST_POS = 16'h7FFF;

   localparam u64_type Q31_ONE        = u64_type'(1) << 31;
   localparam int      RANDOM_ITEMS   = 1825;
   localparam int      WATCHDOG_LIMIT = 3000;
   localparam int      HOLD_OFF_AT    = 200;
   localparam int      HOLD_OFF_LEN   = 300;
   localparam int      DRAIN_CYCLES   = 10;

   localparam stim_row_type DIRECTED_ROWS [24] = '{
      '{KIND_LINEAR,  16'h0000,   16'h0000,     1'b0, 1'b1, 16'h0000},
      '{KIND_LINEAR,  MOST_NEG,   MOST_POS,     1'b0, 1'b1, MOST_POS},
      '{KIND_LINEAR,  MOST_POS,   MOST_NEG,     1'b1, 1'b1, MOST_NEG},
      '{KIND_RELU,    16'h0001,   MOST_NEG,     1'b0, 1'b1, MOST_NEG},
      '{KIND_RELU,    16'h0000,   16'd12345,    1'b0, 1'b1, 16'h0000},
      '{KIND_RELU,    MOST_NEG,   MOST_POS,     1'b0, 1'b1, 16'h0000},
      '{KIND_RELU,    MOST_POS,   16'hFFFF,     1'b1, 1'b1, 16'hFFFF},
      '{KIND_LEAKY,   16'h0000,   16'd100,      1'b0, 1'b1, 16'd10},
      '{KIND_LEAKY,   16'hFFFF,   16'(-15),     1'b0, 1'b1, 16'(-2)},
      '{KIND_LEAKY,   MOST_NEG,   MOST_POS,     1'b0, 1'b1, 16'd3277},
      '{KIND_LEAKY,   16'hFFFF,   MOST_NEG,     1'b1, 1'b1, 16'(-3277)},
      '{KIND_LEAKY,   16'h0005,   MOST_NEG,     1'b0, 1'b1, MOST_NEG},
      '{KIND_SIGMOID, 16'h0000,   16'd4096,     1'b0, 1'b1, 16'd1024},
      '{KIND_SIGMOID, 16'h0000,   16'h0000,     1'b0, 1'b1, 16'h0000},
      '{KIND_SIGMOID, MOST_NEG,   MOST_POS,     1'b0, 1'b0, 16'h0000},
      '{KIND_SIGMOID, MOST_POS,   MOST_NEG,     1'b1, 1'b0, 16'h0000},
      '{KIND_SIGMOID, 16'hF000,   16'd1234,     1'b0, 1'b0, 16'h0000},
      '{KIND_ELU,     16'h0000,   MOST_NEG,     1'b0, 1'b1, MOST_NEG},
      '{KIND_ELU,     16'h0001,   MOST_POS,     1'b0, 1'b1, MOST_POS},
      '{KIND_ELU,     MOST_NEG,   MOST_POS,     1'b0, 1'b0, 16'h0000},
      '{KIND_ELU,     16'hF000,   16'(-12345),  1'b1, 1'b0, 16'h0000},
      '{KIND_SPARE5,  16'hFFFF,   MOST_NEG,     1'b0, 1'b1, MOST_NEG},
      '{KIND_SPARE6,  16'h0000,   16'h0001,     1'b0, 1'b1, 16'h0001},
      '{KIND_SPARE7,  16'd100,    MOST_POS,     1'b1, 1'b1, MOST_POS}
   };

   localparam logic [2:0] KIND_ORDER [8] = '{
      KIND_SIGMOID, KIND_ELU, KIND_LEAKY, KIND_RELU,
      KIND_LINEAR, KIND_SPARE7, KIND_SPARE5, KIND_SPARE6
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_data = '0;

   // expectation typed into a directed row travels beside the request
   logic        req_known = 1'b0;
   logic [15:0] req_known_grad = '0;

   u64_type exp_decay_table [TABLE_ENTRIES + 2];
   u64_type sig_slope_table [TABLE_ENTRIES + 2];

   grad_result_type pending_grads [$];
   logic [2:0]      active_kind = KIND_LINEAR;
   int              error_count = 0;
   int              accepted_items = 0;
   int              quiet_cycles = 0;
   bit              sender_burst = 1'b0;
   bit              long_hold_done = 1'b0;

   activation_derivative_gradient dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic u64_type exp_series(input u64_type f);
      u64_type term;
      longint  acc;
      term = Q31_ONE;
      acc  = longint'(Q31_ONE);
      for (int i = 1; i <= 24; i++) begin
         term = ((term * f) >> 31) / u64_type'(i);
         if (i % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      if (acc > longint'(Q31_ONE)) begin
         acc = longint'(Q31_ONE);
      end
      return u64_type'(acc);
   endfunction

   initial begin : build_slopes
      u64_type e1, u, n, e, d, s, sd;
      e1 = exp_series(Q31_ONE);
      for (int k = 0; k <= TABLE_ENTRIES; k++) begin
         u = (u64_type'(k) << (46 - FRAC_BITS)) / u64_type'(TABLE_ENTRIES);
         n = u >> 31;
         e = exp_series(u & (Q31_ONE - 1));
         while (n > 0 && e != 0) begin
            e = (e * e1) >> 31;
            n = n - 1;
         end
         d = Q31_ONE + e;
         s = ((u64_type'(1) << 62) + (d >> 1)) / d;
         if (s > Q31_ONE) begin
            s = Q31_ONE;
         end
         sd = (s * (Q31_ONE - s)) >> 31;
         exp_decay_table[k] = (e + (u64_type'(1) << 14)) >> 15;
         sig_slope_table[k] = (sd + (u64_type'(1) << 14)) >> 15;
      end
      exp_decay_table[TABLE_ENTRIES + 1] = exp_decay_table[TABLE_ENTRIES];
      sig_slope_table[TABLE_ENTRIES + 1] = sig_slope_table[TABLE_ENTRIES];
   end

   function automatic u64_type slope_factor(input bit use_sig, input int unsigned m);
      u64_type p, idx, w, lo, hi;
      p   = u64_type'(m) * u64_type'(TABLE_ENTRIES);
      idx = p >> 15;
      w   = p & u64_type'(16'h7FFF);
      if (idx > u64_type'(TABLE_ENTRIES)) begin
         idx = u64_type'(TABLE_ENTRIES);
      end
      lo = use_sig ? sig_slope_table[idx] : exp_decay_table[idx];
      hi = use_sig ? sig_slope_table[idx + 1] : exp_decay_table[idx + 1];
      return lo * (u64_type'(32768) - w) + hi * w;
   endfunction

   function automatic int scale_gradient(input int y, input u64_type factor);
      u64_type mag, q;
      mag = u64_type'(y < 0 ? -y : y);
      q   = (mag * factor + (u64_type'(1) << 30)) >> 31;
      return y < 0 ? -int'(q) : int'(q);
   endfunction

   function automatic int tenth_of(input int y);
      int q;
      q = ((y < 0 ? -y : y) + 5) / 10;
      return y < 0 ? -q : q;
   endfunction

   function automatic logic [15:0] derive_gradient(input logic [2:0] kind,
                                                   input logic [15:0] x_bits,
                                                   input logic [15:0] y_bits);
      int          x, y, r;
      int unsigned m;
      x = int'($signed(x_bits));
      y = int'($signed(y_bits));
      m = int'(x < 0 ? -x : x);
      case (kind)
         KIND_RELU: begin
            r = x > 0 ? y : 0;
         end
         KIND_LEAKY: begin
            r = x > 0 ? y : tenth_of(y);
         end
         KIND_SIGMOID: begin
            r = scale_gradient(y, slope_factor(1'b1, m));
         end
         KIND_ELU: begin
            r = x > 0 ? y : scale_gradient(y, slope_factor(1'b0, m));
         end
         default: begin
            r = y;
         end
      endcase
      if (r > 32767) begin
         r = 32767;
      end
      if (r < -32768) begin
         r = -32768;
      end
      return r[15:0];
   endfunction

   task automatic report_mismatch(input string what, input int want, input int got);
      error_count++;
      if (error_count <= 10) begin
         $display("mismatch %0s: expected %0d, got %0d", what, want, got);
      end
   endtask

   // track transfers on both streams at the same edge, inputs first
   always @(posedge clock) begin
      grad_result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            want.grad = req_known ? req_known_grad
                      : derive_gradient(active_kind, req_tdata[15:0], req_tdata[31:16]);
            want.last = req_tlast;
            pending_grads.push_back(want);
            accepted_items++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_grads.size() == 0) begin
               report_mismatch("unexpected transfer, gradient", 0, $signed(rsp_tdata));
            end else begin
               want = pending_grads.pop_front();
               if (rsp_tdata !== want.grad) begin
                  report_mismatch("gradient", $signed(want.grad), $signed(rsp_tdata));
               end
               if (rsp_tlast !== want.last) begin
                  report_mismatch("last", want.last, rsp_tlast);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver: random stalls, one long hold-off once traffic is flowing
   initial begin
      int stall;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (!long_hold_done && accepted_items >= HOLD_OFF_AT) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_LEN) @(posedge clock);
            long_hold_done = 1'b1;
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(0, 9) == 0 ? $urandom_range(50, 200)
                                           : $urandom_range(1, 40)) @(posedge clock);
         stall = $urandom_range(0, 99);
         rsp_tready <= 1'b0;
         if (stall < 70) begin
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else if (stall < 95) begin
            repeat ($urandom_range(4, 10)) @(posedge clock);
         end else begin
            repeat ($urandom_range(20, 60)) @(posedge clock);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (sender_burst || r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end else if (r < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(30, 60);
   endfunction

   function automatic logic [15:0] draw_fixed();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         case ($urandom_range(0, 4))
            0: return MOST_NEG;
            1: return MOST_POS;
            2: return 16'h0000;
            3: return 16'h0001;
            default: return 16'hFFFF;
         endcase
      end else if (r == 1) begin
         return 16'($urandom_range(0, 1) ? $urandom_range(0, 255) : -$urandom_range(0, 255));
      end
      return 16'($urandom);
   endfunction

   task automatic send_item(input logic [15:0] x, input logic [15:0] y, input logic last,
                            input logic known, input logic [15:0] grad);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid     <= 1'b1;
      req_tdata      <= {y, x};
      req_tlast      <= last;
      req_known      <= known;
      req_known_grad <= grad;
      do @(posedge clock); while (!req_tready);
   endtask

   // drain the pipe, then transfer one register write
   task automatic write_kind(input logic [2:0] kind);
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_grads.size() != 0) @(negedge clock);
      repeat (6) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= kind;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      active_kind = kind;
   endtask

   initial begin
      int sent;
      int phase;
      int span;
      stim_row_type row;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i]) begin
         row = DIRECTED_ROWS[i];
         if (row.kind != active_kind) begin
            write_kind(row.kind);
         end
         send_item(row.x, row.y, row.last, row.known, row.grad);
      end

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         write_kind(phase < 8 ? KIND_ORDER[phase] : 3'($urandom_range(0, 7)));
         sender_burst = ($urandom_range(0, 3) == 0);
         span = $urandom_range(40, 260);
         if (span > RANDOM_ITEMS - sent) begin
            span = RANDOM_ITEMS - sent;
         end
         repeat (span) begin
            send_item(draw_fixed(), draw_fixed(), $urandom_range(0, 7) == 0, 1'b0, 16'h0000);
            sent++;
         end
         phase++;
      end

      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_grads.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_grads.size() != 0) begin
         report_mismatch("results still outstanding", 0, pending_grads.size());
      end
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/adg_pkg.sv
sv/activation_derivative_gradient.sv
sv/adg_checker.sv
tb/activation_derivative_gradient_test.sv
